/* rtl/acps_pkg.sv */
// Shared types and constants for the AT command port switch.
package acps_pkg;

    // Command class, live matching classes first, then decided ones.
    typedef enum logic [3:0] {
        CL_PRE     = 4'd0,
        CL_GMR     = 4'd1,
        CL_PORT    = 4'd2,
        CL_EQ      = 4'd3,
        CL_IDENT   = 4'd4,
        CL_UNKNOWN = 4'd5,
        CL_REPORT  = 4'd6,
        CL_COUNT   = 4'd7,
        CL_BADPORT = 4'd8,
        CL_ROUTE0  = 4'd9,
        CL_ROUTE1  = 4'd10,
        CL_ROUTE2  = 4'd11,
        CL_ROUTE3  = 4'd12,
        CL_ROUTE4  = 4'd13,
        CL_OK      = 4'd14
    } t_class;

    // Response codes.
    localparam logic [2:0] C_RESP_OK      = 3'd0;
    localparam logic [2:0] C_RESP_IDENT   = 3'd1;
    localparam logic [2:0] C_RESP_REPORT  = 3'd2;
    localparam logic [2:0] C_RESP_COUNT   = 3'd3;
    localparam logic [2:0] C_RESP_BADPORT = 3'd4;
    localparam logic [2:0] C_RESP_UNKNOWN = 3'd5;

    // Switch path and direction codes.
    localparam logic [1:0] C_PATH_NONE = 2'd0;
    localparam logic [1:0] C_PATH_C    = 2'd1;
    localparam logic [1:0] C_PATH_D    = 2'd2;
    localparam logic [1:0] C_DIR_OFF   = 2'd0;
    localparam logic [1:0] C_DIR_SINK  = 2'd1;
    localparam logic [1:0] C_DIR_SRC   = 2'd2;

    // Default depth of the class queue between front and back.
    localparam int C_QUEUE_DEPTH = 4;

    // Push word from the front end into the queue.
    typedef struct packed {
        logic   valid;
        t_class cls;
    } t_push;

    // Queue status seen by both neighbors.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

/* rtl/at_command_port_switch_top.sv */
// Top level of the AT command port switch recognizer.
// The block takes one command character per word on the input channel, with
// i_last_char marking the end of the line, and sustains one word per clock
// while the queue is not full. A front end keeps the character position
// (saturating at 9) and the match class, a single small compare and update
// per word; on the last character it pushes the final class into a short
// queue. A back end pops the class and turns it into the response code and
// switch drive, keeps the selected routing, and registers the result word.
// Recognized lines are exact "AT", "AT+GMR...", "AT+PORT=0".."AT+PORT=4",
// "AT+PORT=?" and "AT+PORT?", all by prefix; a zero byte ends the line text
// early. Only the last character of a line yields a result word; it is queued
// and then registered by the back end. Input stall rises only when the queue
// (QUEUE_DEPTH entries) is full because the output side has been stalled.
module at_command_port_switch_top
    import acps_pkg::*;
#(
    parameter int QUEUE_DEPTH = C_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_command_char,
    input  logic       i_last_char,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_response,
    output logic       o_drive_switch,
    output logic       o_break_first,
    output logic [1:0] o_path_select,
    output logic [1:0] o_path_direction,
    output logic [2:0] o_current_routing
);

    t_push     push;
    t_q_status q_status;
    t_class    head;
    logic      pop;

    // classify characters
    acps_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_command_char (i_command_char),
        .i_last_char    (i_last_char),
        .i_q_status     (q_status),
        .o_in_stall     (o_in_stall),
        .o_push         (push)
    );

    // decouples front from back
    acps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // execute command, drive switch
    acps_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head),
        .i_q_status        (q_status),
        .i_out_stall       (i_out_stall),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .o_response        (o_response),
        .o_drive_switch    (o_drive_switch),
        .o_break_first     (o_break_first),
        .o_path_select     (o_path_select),
        .o_path_direction  (o_path_direction),
        .o_current_routing (o_current_routing)
    );

endmodule

/* rtl/acps_front.sv */
// Front end: tracks character position and match class, pushes final class.
module acps_front
    import acps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic [7:0] i_command_char,
    input  logic      i_last_char,
    input  t_q_status i_q_status,
    output logic      o_in_stall,
    output t_push     o_push
);

    localparam logic [3:0] POS_MAX = 4'd9;

    logic [3:0] r_pos, n_pos;
    t_class     r_cls, n_cls;
    logic       accept;
    t_class     cls_a;
    logic [3:0] pos_inc;

    // class once the line text ends
    function automatic t_class end_of_text(input t_class cls, input logic [3:0] pos);
        t_class res;
        case (cls)
            CL_PRE:  res = (pos == 4'd2) ? CL_OK : CL_UNKNOWN;
            CL_GMR:  res = CL_UNKNOWN;
            CL_PORT: res = CL_UNKNOWN;
            CL_EQ:   res = CL_BADPORT;
            default: res = cls;
        endcase
        return res;
    endfunction

    // class after one non-zero character in a live class
    function automatic t_class advance(input t_class cls, input logic [3:0] pos,
                                       input logic [7:0] c);
        t_class res;
        res = CL_UNKNOWN;
        case (cls)
            CL_PRE: begin
                case (pos)
                    4'd0: res = (c == "A") ? CL_PRE : CL_UNKNOWN;
                    4'd1: res = (c == "T") ? CL_PRE : CL_UNKNOWN;
                    4'd2: res = (c == "+") ? CL_PRE : CL_UNKNOWN;
                    4'd3: begin
                        if (c == "G")
                            res = CL_GMR;
                        else if (c == "P")
                            res = CL_PORT;
                    end
                    default: res = CL_UNKNOWN;
                endcase
            end
            CL_GMR: begin
                if (pos == 4'd4 && c == "M")
                    res = CL_GMR;
                else if (pos == 4'd5 && c == "R")
                    res = CL_IDENT;
            end
            CL_PORT: begin
                case (pos)
                    4'd4: res = (c == "O") ? CL_PORT : CL_UNKNOWN;
                    4'd5: res = (c == "R") ? CL_PORT : CL_UNKNOWN;
                    4'd6: res = (c == "T") ? CL_PORT : CL_UNKNOWN;
                    4'd7: begin
                        if (c == "=")
                            res = CL_EQ;
                        else if (c == "?")
                            res = CL_REPORT;
                    end
                    default: res = CL_UNKNOWN;
                endcase
            end
            CL_EQ: begin
                res = CL_BADPORT;
                if (pos == 4'd8) begin
                    if (c >= "0" && c <= "4")
                        res = t_class'(4'(CL_ROUTE0) + {1'b0, c[2:0]});
                    else if (c == "?")
                        res = CL_COUNT;
                end
            end
            default: res = cls;
        endcase
        return res;
    endfunction

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;

    always_comb begin
        if (r_cls == CL_PRE || r_cls == CL_GMR || r_cls == CL_PORT || r_cls == CL_EQ) begin
            if (i_command_char == 8'd0)
                cls_a = end_of_text(r_cls, r_pos);
            else
                cls_a = advance(r_cls, r_pos, i_command_char);
        end else begin
            cls_a = r_cls;
        end
        pos_inc = (r_pos < POS_MAX) ? r_pos + 4'd1 : r_pos;

        n_pos        = r_pos;
        n_cls        = r_cls;
        o_push.valid = 1'b0;
        o_push.cls   = end_of_text(cls_a, pos_inc);
        if (accept) begin
            if (i_last_char) begin
                o_push.valid = 1'b1;
                n_pos        = 4'd0;
                n_cls        = CL_PRE;
            end else begin
                n_pos = pos_inc;
                n_cls = cls_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 4'd0;
            r_cls <= CL_PRE;
        end else begin
            r_pos <= n_pos;
            r_cls <= n_cls;
        end
    end

    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("char position past saturation");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last_char |=> r_pos == 4'd0 && r_cls == CL_PRE)
        else $error("matcher not restarted after last char");

endmodule

/* rtl/acps_queue.sv */
// Short class queue between the front end and the back end.
module acps_queue
    import acps_pkg::*;
#(
    parameter int DEPTH = C_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    input  logic      i_pop,
    output t_class    o_head,
    output t_q_status o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_class          r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_status.empty = (r_count == CW'(0));
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign do_push        = i_push.valid && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr] <= i_push.cls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push)
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            if (do_pop)
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            if (do_push && !do_pop)
                r_count <= r_count + CW'(1);
            else if (do_pop && !do_push)
                r_count <= r_count - CW'(1);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.valid && o_status.full))
        else $error("push into full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

/* rtl/acps_back.sv */
// Back end: decodes a class into response and switch drive, holds routing.
module acps_back
    import acps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_class    i_head,
    input  t_q_status i_q_status,
    input  logic      i_out_stall,
    output logic      o_pop,
    output logic      o_out_valid,
    output logic [2:0] o_response,
    output logic      o_drive_switch,
    output logic      o_break_first,
    output logic [1:0] o_path_select,
    output logic [1:0] o_path_direction,
    output logic [2:0] o_current_routing
);

    logic       r_valid;
    logic [2:0] r_routing, n_routing;
    logic [2:0] r_response, n_response;
    logic       r_drive, n_drive;
    logic       r_break, n_break;
    logic [1:0] r_path, n_path;
    logic [1:0] r_dir, n_dir;
    logic [2:0] r_out_routing;
    logic [2:0] route;

    assign o_pop = !i_q_status.empty && (!r_valid || !i_out_stall);
    assign route = 3'(i_head - CL_ROUTE0);

    always_comb begin
        n_response = C_RESP_UNKNOWN;
        n_drive    = 1'b0;
        n_break    = 1'b0;
        n_path     = C_PATH_NONE;
        n_dir      = C_DIR_OFF;
        n_routing  = r_routing;
        case (i_head)
            CL_OK:      n_response = C_RESP_OK;
            CL_IDENT:   n_response = C_RESP_IDENT;
            CL_REPORT:  n_response = C_RESP_REPORT;
            CL_COUNT:   n_response = C_RESP_COUNT;
            CL_BADPORT: n_response = C_RESP_BADPORT;
            CL_ROUTE0, CL_ROUTE1, CL_ROUTE2, CL_ROUTE3, CL_ROUTE4: begin
                n_response = C_RESP_OK;
                n_drive    = 1'b1;
                n_routing  = route;
                if (route != 3'd0) begin
                    n_break = 1'b1;
                    n_path  = (route == 3'd1 || route == 3'd3) ? C_PATH_C : C_PATH_D;
                    n_dir   = (route <= 3'd2) ? C_DIR_SINK : C_DIR_SRC;
                end
            end
            default: begin
                // unknown line: disable only, stored routing kept
                n_response = C_RESP_UNKNOWN;
                n_drive    = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_routing <= 3'd0;
        end else begin
            if (o_pop) begin
                r_valid   <= 1'b1;
                r_routing <= n_routing;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_response    <= n_response;
            r_drive       <= n_drive;
            r_break       <= n_break;
            r_path        <= n_path;
            r_dir         <= n_dir;
            r_out_routing <= n_routing;
        end
    end

    assign o_out_valid       = r_valid;
    assign o_response        = r_response;
    assign o_drive_switch    = r_drive;
    assign o_break_first     = r_break;
    assign o_path_select     = r_path;
    assign o_path_direction  = r_dir;
    assign o_current_routing = r_out_routing;

    a_break_has_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_break |-> r_drive && r_path != C_PATH_NONE
                               && r_dir != C_DIR_OFF && r_out_routing != 3'd0)
        else $error("break-first without an enabled path");

    a_routing_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_routing == r_routing)
        else $error("reported routing differs from stored routing");

endmodule

/* sim/tb_at_command_port_switch_top.sv */
// Self-checking testbench for at_command_port_switch_top: directed and random command lines.
`timescale 1ns / 1ps

module tb_at_command_port_switch_top;
    import acps_pkg::*;

    // Stored routing codes, as reported on o_current_routing.
    localparam logic [2:0] ROUTE_OFF = 3'd0;
    localparam logic [2:0] ROUTE_A_C = 3'd1;
    localparam logic [2:0] ROUTE_A_B = 3'd2;
    localparam logic [2:0] ROUTE_C_A = 3'd3;
    localparam logic [2:0] ROUTE_B_A = 3'd4;

    // Run limits. The watchdog sits far above the slowest legal run.
    localparam int unsigned WATCHDOG_CYCLES = 200_000;
    localparam int          DRAIN_CYCLES    = 16;
    localparam int          RANDOM_CHARS    = 700;
    localparam int          NUM_PHASES      = 4;
    localparam int          MAX_REPORTS     = 10;

    // One result word, field order as on the output ports.
    typedef struct packed {
        logic [2:0] response;
        logic       drive;
        logic       brk;
        logic [1:0] path;
        logic [1:0] dir;
        logic [2:0] routing;
    } t_result;

    // Directed command line. zero_at marks the character replaced by a zero
    // byte (-1 for none). Rows with has_want carry a result typed in by hand.
    typedef struct {
        string   text;
        int      zero_at;
        bit      has_want;
        t_result want;
    } t_line;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic [7:0] i_command_char = 8'h00;
    logic       i_last_char    = 1'b0;
    logic       i_out_stall    = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [2:0] o_response;
    logic       o_drive_switch;
    logic       o_break_first;
    logic [1:0] o_path_select;
    logic [1:0] o_path_direction;
    logic [2:0] o_current_routing;

    at_command_port_switch_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command_char    (i_command_char),
        .i_last_char       (i_last_char),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_response        (o_response),
        .o_drive_switch    (o_drive_switch),
        .o_break_first     (o_break_first),
        .o_path_select     (o_path_select),
        .o_path_direction  (o_path_direction),
        .o_current_routing (o_current_routing)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow state of the recognizer
    logic [3:0] line_pos     = 4'd0;
    t_class     line_cls     = CL_PRE;
    logic [2:0] held_routing = ROUTE_OFF;

    t_result pending_results [$];
    int      n_errors    = 0;
    int      chars_taken = 0;
    int      idle_pct    = 0;
    int      stall_pct   = 0;

    // Class once the line text has ended.
    function automatic t_class class_at_text_end(t_class cls, logic [3:0] pos);
        case (cls)
            CL_PRE:          return (pos == 4'd2) ? CL_OK : CL_UNKNOWN;
            CL_GMR, CL_PORT: return CL_UNKNOWN;
            CL_EQ:           return CL_BADPORT;
            default:         return cls;
        endcase
    endfunction

    // Class after one non-zero character while still matching.
    function automatic t_class class_after_char(t_class cls, logic [3:0] pos,
                                                logic [7:0] c);
        case (cls)
            CL_PRE: begin
                case (pos)
                    4'd0: return (c == "A") ? CL_PRE : CL_UNKNOWN;
                    4'd1: return (c == "T") ? CL_PRE : CL_UNKNOWN;
                    4'd2: return (c == "+") ? CL_PRE : CL_UNKNOWN;
                    4'd3: begin
                        if (c == "G") return CL_GMR;
                        if (c == "P") return CL_PORT;
                        return CL_UNKNOWN;
                    end
                    default: return CL_UNKNOWN;
                endcase
            end
            CL_GMR: begin
                if (pos == 4'd4 && c == "M") return CL_GMR;
                if (pos == 4'd5 && c == "R") return CL_IDENT;
                return CL_UNKNOWN;
            end
            CL_PORT: begin
                case (pos)
                    4'd4: return (c == "O") ? CL_PORT : CL_UNKNOWN;
                    4'd5: return (c == "R") ? CL_PORT : CL_UNKNOWN;
                    4'd6: return (c == "T") ? CL_PORT : CL_UNKNOWN;
                    4'd7: begin
                        if (c == "=") return CL_EQ;
                        if (c == "?") return CL_REPORT;
                        return CL_UNKNOWN;
                    end
                    default: return CL_UNKNOWN;
                endcase
            end
            CL_EQ: begin
                if (pos != 4'd8) return CL_BADPORT;
                case (c)
                    "0":     return CL_ROUTE0;
                    "1":     return CL_ROUTE1;
                    "2":     return CL_ROUTE2;
                    "3":     return CL_ROUTE3;
                    "4":     return CL_ROUTE4;
                    "?":     return CL_COUNT;
                    default: return CL_BADPORT;
                endcase
            end
            default: return cls;
        endcase
    endfunction

    // Advance the shadow recognizer by one taken word. Sets has_res and res
    // when the word closes a line.
    task automatic predict_char(input logic [7:0] c, input logic last,
                                output bit has_res, output t_result res);
        t_class cls;
        cls     = line_cls;
        res     = '0;
        has_res = 1'b0;
        // a zero byte freezes the class as if the text had ended there
        if (cls <= CL_EQ)
            cls = (c == 8'h00) ? class_at_text_end(cls, line_pos)
                               : class_after_char(cls, line_pos, c);
        if (line_pos < 4'd9)
            line_pos++;
        if (!last) begin
            line_cls = cls;
            return;
        end
        cls = class_at_text_end(cls, line_pos);
        case (cls)
            CL_OK:      res.response = C_RESP_OK;
            CL_IDENT:   res.response = C_RESP_IDENT;
            CL_REPORT:  res.response = C_RESP_REPORT;
            CL_COUNT:   res.response = C_RESP_COUNT;
            CL_BADPORT: res.response = C_RESP_BADPORT;
            CL_ROUTE0: begin
                // disable only, no settle wait
                res.response = C_RESP_OK;
                res.drive    = 1'b1;
                held_routing = ROUTE_OFF;
            end
            CL_ROUTE1, CL_ROUTE2, CL_ROUTE3, CL_ROUTE4: begin
                held_routing = 3'(cls - CL_ROUTE0);
                res.response = C_RESP_OK;
                res.drive    = 1'b1;
                res.brk      = 1'b1;
                res.path     = (held_routing == ROUTE_A_C || held_routing == ROUTE_C_A)
                               ? C_PATH_C : C_PATH_D;
                res.dir      = (held_routing <= ROUTE_A_B) ? C_DIR_SINK : C_DIR_SRC;
            end
            default: begin
                // unknown: switch is disabled, stored routing untouched
                res.response = C_RESP_UNKNOWN;
                res.drive    = 1'b1;
            end
        endcase
        res.routing = held_routing;
        has_res     = 1'b1;
        line_pos    = 4'd0;
        line_cls    = CL_PRE;
    endtask

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Drive one word; called and returns at a falling edge. The prediction is
    // taken at the accepting edge.
    task automatic send_char(input logic [7:0] c, input logic last,
                             input bit has_want, input t_result want);
        bit      has_res;
        t_result res;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command_char <= c;
        i_last_char    <= last;
        do
            @(posedge i_clk);
        while (o_in_stall);
        chars_taken++;
        predict_char(c, last, has_res, res);
        if (has_res)
            pending_results.push_back(has_want ? want : res);
        @(negedge i_clk);
    endtask

    task automatic send_line(input logic [7:0] bytes [$], input bit has_want,
                             input t_result want);
        foreach (bytes[i])
            send_char(bytes[i], i == bytes.size() - 1, has_want, want);
    endtask

    // Hold the sender off until the block has nothing left to deliver.
    // Returns at a later falling edge than the one it was called at.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (pending_results.size() != 0);
    endtask

    // Output side: random stall, as set by the current phase.
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result checker: every taken result word is matched against the oldest
    // expectation.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_response, o_drive_switch, o_break_first, o_path_select,
                    o_path_direction, o_current_routing};
            if (pending_results.size() == 0) begin
                note_error($sformatf({"unexpected word resp=%0d drv=%0b brk=%0b",
                                      " path=%0d dir=%0d route=%0d"},
                    got.response, got.drive, got.brk, got.path, got.dir, got.routing));
            end else begin
                want = pending_results.pop_front();
                if (got !== want)
                    note_error($sformatf({"mismatch exp resp=%0d drv=%0b brk=%0b",
                                          " path=%0d dir=%0d route=%0d",
                                          " got resp=%0d drv=%0b brk=%0b",
                                          " path=%0d dir=%0d route=%0d"},
                        want.response, want.drive, want.brk, want.path, want.dir,
                        want.routing, got.response, got.drive, got.brk, got.path,
                        got.dir, got.routing));
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Directed lines. Typed results follow from reset, the fixed routing
    // table and the error codes; the rest go through the predictor.
    t_line directed_lines [24] = '{
        '{"AT",           -1, 1, '{C_RESP_OK,      1'b0, 1'b0, C_PATH_NONE, C_DIR_OFF, ROUTE_OFF}},
        '{"A",            -1, 1, '{C_RESP_UNKNOWN, 1'b1, 1'b0, C_PATH_NONE, C_DIR_OFF, ROUTE_OFF}},
        '{"AT+GMR",       -1, 1, '{C_RESP_IDENT,   1'b0, 1'b0, C_PATH_NONE, C_DIR_OFF, ROUTE_OFF}},
        '{"AT+GMRXYZ123", -1, 0, '0},
        '{"z",             0, 1, '{C_RESP_UNKNOWN, 1'b1, 1'b0, C_PATH_NONE, C_DIR_OFF, ROUTE_OFF}},
        '{"AT+PORT=1",    -1, 1, '{C_RESP_OK,      1'b1, 1'b1, C_PATH_C,    C_DIR_SINK, ROUTE_A_C}},
        '{"AT+PORT=2",    -1, 1, '{C_RESP_OK,      1'b1, 1'b1, C_PATH_D,    C_DIR_SINK, ROUTE_A_B}},
        '{"AT+PORT=3",    -1, 1, '{C_RESP_OK,      1'b1, 1'b1, C_PATH_C,    C_DIR_SRC,  ROUTE_C_A}},
        '{"AT+PORT=4",    -1, 1, '{C_RESP_OK,      1'b1, 1'b1, C_PATH_D,    C_DIR_SRC,  ROUTE_B_A}},
        '{"AT+PORT?",     -1, 1, '{C_RESP_REPORT,  1'b0, 1'b0, C_PATH_NONE, C_DIR_OFF, ROUTE_B_A}},
        '{"AT+PORT=?",    -1, 1, '{C_RESP_COUNT,   1'b0, 1'b0, C_PATH_NONE, C_DIR_OFF, ROUTE_B_A}},
        '{"AT+PORT=5",    -1, 1, '{C_RESP_BADPORT, 1'b0, 1'b0, C_PATH_NONE, C_DIR_OFF, ROUTE_B_A}},
        '{"AT+PORT=",     -1, 1, '{C_RESP_BADPORT, 1'b0, 1'b0, C_PATH_NONE, C_DIR_OFF, ROUTE_B_A}},
        '{"AT+PORTX",     -1, 1, '{C_RESP_UNKNOWN, 1'b1, 1'b0, C_PATH_NONE, C_DIR_OFF, ROUTE_B_A}},
        '{"AT+PORT",      -1, 1, '{C_RESP_UNKNOWN, 1'b1, 1'b0, C_PATH_NONE, C_DIR_OFF, ROUTE_B_A}},
        '{"AT+GM",        -1, 1, '{C_RESP_UNKNOWN, 1'b1, 1'b0, C_PATH_NONE, C_DIR_OFF, ROUTE_B_A}},
        '{"AT+",          -1, 1, '{C_RESP_UNKNOWN, 1'b1, 1'b0, C_PATH_NONE, C_DIR_OFF, ROUTE_B_A}},
        '{"ATzz",          2, 1, '{C_RESP_OK,      1'b0, 1'b0, C_PATH_NONE, C_DIR_OFF, ROUTE_B_A}},
        '{"AT+PORT=z",     8, 1, '{C_RESP_BADPORT, 1'b0, 1'b0, C_PATH_NONE, C_DIR_OFF, ROUTE_B_A}},
        '{"ATX",          -1, 0, '0},
        '{"\377\200\177", -1, 0, '0},
        '{"AT+PORT=?xyz", -1, 0, '0},
        '{"AT+PORT=0",    -1, 1, '{C_RESP_OK,      1'b1, 1'b0, C_PATH_NONE, C_DIR_OFF, ROUTE_OFF}},
        '{"at",           -1, 0, '0}
    };

    // Seeds for the random lines: complete commands, their prefixes and a bad port.
    string line_seeds [14] = '{
        "AT", "AT+GMR", "AT+PORT=0", "AT+PORT=1", "AT+PORT=2", "AT+PORT=3",
        "AT+PORT=4", "AT+PORT=?", "AT+PORT?", "AT+PORT=", "AT+PORT", "AT+GM",
        "AT+PORT=9", "AT+"
    };

    // Idle and stall odds per phase, in percent.
    int phase_idle  [NUM_PHASES] = '{0, 61, 0, 22};
    int phase_stall [NUM_PHASES] = '{0, 0, 61, 22};

    // Random line: half are seeds, some with random tails; the rest are
    // mutated, cut short, broken by a zero byte, or pure noise.
    task automatic build_random_line(output logic [7:0] bytes [$]);
        string seed;
        int    kind;
        int    cut;
        bytes.delete();
        seed = line_seeds[$urandom_range(13)];
        kind = $urandom_range(99);
        if (kind < 88) begin
            for (int i = 0; i < seed.len(); i++)
                bytes.push_back(seed[i]);
        end
        if (kind < 50) begin
            // prefix match: anything after the deciding position is ignored
            if ($urandom_range(1))
                repeat ($urandom_range(1, 4))
                    bytes.push_back(8'($urandom_range(32, 126)));
        end else if (kind < 65) begin
            bytes[$urandom_range(bytes.size() - 1)] = 8'($urandom_range(1, 255));
        end else if (kind < 75) begin
            cut = $urandom_range(1, bytes.size());
            while (bytes.size() > cut)
                void'(bytes.pop_back());
        end else if (kind < 88) begin
            // zero byte ends the text early; the tail is arbitrary
            cut = $urandom_range(0, bytes.size());
            while (bytes.size() > cut)
                void'(bytes.pop_back());
            bytes.push_back(8'h00);
            repeat ($urandom_range(0, 3))
                bytes.push_back(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 14))
                bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    initial begin
        logic [7:0] bytes [$];
        int         phase_start;
        // apply reset, then release it
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part, no idling on either side
        foreach (directed_lines[k]) begin
            bytes.delete();
            for (int i = 0; i < directed_lines[k].text.len(); i++)
                bytes.push_back((i == directed_lines[k].zero_at) ? 8'h00
                                                                 : directed_lines[k].text[i]);
            send_line(bytes, directed_lines[k].has_want, directed_lines[k].want);
        end
        wait_drained();

        // random part, one share per idling phase; each phase ends with the
        // sender held back until every result is out
        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_pct    = phase_idle[p];
            stall_pct   = phase_stall[p];
            phase_start = chars_taken;
            while (chars_taken - phase_start < RANDOM_CHARS / NUM_PHASES) begin
                build_random_line(bytes);
                send_line(bytes, 1'b0, '0);
            end
            wait_drained();
        end

        // stray words after the last one would show up here
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0)
            note_error($sformatf("%0d results never arrived", pending_results.size()));

        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
rtl/acps_pkg.sv
rtl/acps_front.sv
rtl/acps_queue.sv
rtl/acps_back.sv
rtl/at_command_port_switch_top.sv
sim/tb_at_command_port_switch_top.sv
